// ===== sv/nearest_neighbor_resize_mapper_unit_defines.svh =====
// Assertion macros for the resize mapper's top level.
`ifndef NEAREST_NEIGHBOR_RESIZE_MAPPER_UNIT_DEFINES_SVH
`define NEAREST_NEIGHBOR_RESIZE_MAPPER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define NNRM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define NNRM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/nnrm_pkg.sv =====
// Types and constants shared by the resize mapper modules.
`default_nettype none

package nnrm_pkg;

    // Fixed field widths
    localparam int DIM_W  = 16;
    localparam int EXT_W  = DIM_W + 1;
    localparam int PROD_W = 2 * DIM_W;
    localparam int OFF_W  = 18;
    localparam int CH_W   = 2;
    localparam int CNT_W  = $clog2(PROD_W + 1);
    localparam int CFG_IDX_W  = 3;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 104;
    localparam int OUT_USER_W = 2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IN_WIDTH   = 3'd0,
        REG_IN_HEIGHT  = 3'd1,
        REG_OUT_WIDTH  = 3'd2,
        REG_OUT_HEIGHT = 3'd3,
        REG_CHANNELS   = 3'd4,
        REG_ROW_BEGIN  = 3'd5,
        REG_ROW_END    = 3'd6
    } cfg_reg_t;

    // Operand pair loaded into the shared divider
    typedef enum logic [1:0] {
        DIV_COL,
        DIV_ROW,
        DIV_MAP
    } div_sel_t;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_STEP,
        S_COL_GO,
        S_COL_WAIT,
        S_ROW_GO,
        S_ROW_WAIT,
        S_MUL,
        S_MAP_GO,
        S_MAP_WAIT,
        S_LOAD,
        S_EMIT
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic            set_started;
        logic            clr_started;
        logic            col_reset;
        logic            col_step;
        logic            row_step;
        logic            div_start;
        div_sel_t        div_sel;
        logic            load_col_steps;
        logic            load_row_steps;
        logic            mul_load;
        logic            load_row_map;
        logic            out_load;
        logic [CH_W-1:0] ch;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic            started;
        logic            band_empty;
        logic            col_wrap;
        logic            row_wrap;
        logic            div_done;
        logic [CH_W-1:0] nch;
    } status_t;

    // One result item
    typedef struct packed {
        logic [DIM_W-1:0] src_row;
        logic [DIM_W-1:0] src_col;
        logic [DIM_W-1:0] dst_row;
        logic [DIM_W-1:0] dst_col;
        logic [CH_W-1:0]  channel_index;
        logic [OFF_W-1:0] src_elem_offset;
        logic [OFF_W-1:0] dst_elem_offset;
        logic             last_of_pixel;
        logic             last_of_row;
        logic             last_of_frame;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/nnrm_div.sv =====
// Radix-2 restoring divider: one quotient bit per cycle.
`default_nettype none

module nnrm_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [nnrm_pkg::PROD_W-1:0] dividend,
    input  logic [nnrm_pkg::DIM_W-1:0]  divisor,
    output logic                        done,
    output logic [nnrm_pkg::PROD_W-1:0] quot,
    output logic [nnrm_pkg::DIM_W-1:0]  rem
);
    import nnrm_pkg::*;

    logic [PROD_W-1:0] q_reg, q_next;
    logic [DIM_W-1:0]  rem_reg, rem_next;
    logic [DIM_W-1:0]  d_reg, d_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [EXT_W-1:0]  rem_sh;
    logic [EXT_W-1:0]  rem_sub;
    logic              fits;

    // Trial subtraction of the divisor from the shifted partial remainder
    always_comb
    begin
        rem_sh  = {rem_reg, q_reg[PROD_W-1]};
        fits    = rem_sh >= {1'b0, d_reg};
        rem_sub = rem_sh - {1'b0, d_reg};
    end

    // Iteration control
    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            rem_next  = '0;
            d_next    = divisor;
            cnt_next  = CNT_W'(PROD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[PROD_W-2:0], fits};
            rem_next = fits ? rem_sub[DIM_W-1:0] : rem_sh[DIM_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Operand and result registers
    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

// ===== sv/nnrm_dp.sv =====
// Datapath: configuration, walk registers, rational stepping and result register.
`default_nettype none

module nnrm_dp #(
    parameter int DIM_BITS     = 16,
    parameter int MAX_CHANNELS = 3
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [nnrm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [nnrm_pkg::DIM_W-1:0]     cfg_data,
    input  nnrm_pkg::cmd_t                 cmd,
    output nnrm_pkg::status_t              status,
    output nnrm_pkg::result_t              result
);
    import nnrm_pkg::*;

    localparam logic [2:0] MAX_CH = 3'(MAX_CHANNELS);

    // Configuration registers
    logic [DIM_BITS-1:0] in_width_reg, in_height_reg, out_width_reg, out_height_reg;
    logic [DIM_BITS-1:0] row_begin_reg, row_end_reg;
    logic [CH_W-1:0]     channels_reg;

    // Walk state
    logic [DIM_W-1:0] out_col_reg, out_col_next;
    logic [DIM_W-1:0] out_row_reg, out_row_next;
    logic [DIM_W-1:0] map_col_reg, map_col_next;
    logic [DIM_W-1:0] map_row_reg, map_row_next;
    logic [DIM_W-1:0] col_rem_reg, col_rem_next;
    logic [DIM_W-1:0] row_rem_reg, row_rem_next;
    logic [DIM_W-1:0] col_quot_reg, col_quot_next;
    logic [DIM_W-1:0] col_srem_reg, col_srem_next;
    logic [DIM_W-1:0] row_quot_reg, row_quot_next;
    logic [DIM_W-1:0] row_srem_reg, row_srem_next;
    logic             started_reg, started_next;
    logic [PROD_W-1:0] prod_reg;
    result_t          result_reg;

    // Effective configuration values
    logic [DIM_W-1:0]  iw, ih, ow, oh, rb, re, band_end;
    logic [CH_W-1:0]   ch_raw, nch;

    // Stepping arithmetic
    logic [EXT_W-1:0]  col_sum, col_fix, row_sum, row_fix;
    logic              col_carry, row_carry;

    // Divider hookup
    logic [PROD_W-1:0] div_dividend, div_quot;
    logic [DIM_W-1:0]  div_divisor, div_rem;
    logic              div_done;

    // Result fields
    logic [DIM_W-1:0]  sr, sc;
    logic              col_wrap, row_wrap;
    result_t           res_new;

    // Configuration writes, masked to the dimension width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_width_reg   <= DIM_BITS'(1);
            in_height_reg  <= DIM_BITS'(1);
            out_width_reg  <= DIM_BITS'(1);
            out_height_reg <= DIM_BITS'(1);
            channels_reg   <= CH_W'(1);
            row_begin_reg  <= '0;
            row_end_reg    <= DIM_BITS'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IN_WIDTH:   in_width_reg   <= cfg_data[DIM_BITS-1:0];
                REG_IN_HEIGHT:  in_height_reg  <= cfg_data[DIM_BITS-1:0];
                REG_OUT_WIDTH:  out_width_reg  <= cfg_data[DIM_BITS-1:0];
                REG_OUT_HEIGHT: out_height_reg <= cfg_data[DIM_BITS-1:0];
                REG_CHANNELS:   channels_reg   <= cfg_data[CH_W-1:0];
                REG_ROW_BEGIN:  row_begin_reg  <= cfg_data[DIM_BITS-1:0];
                REG_ROW_END:    row_end_reg    <= cfg_data[DIM_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // A zero dimension counts as one; the band stops at the image bottom
    always_comb
    begin
        iw = (in_width_reg   == '0) ? DIM_W'(1) : DIM_W'(in_width_reg);
        ih = (in_height_reg  == '0) ? DIM_W'(1) : DIM_W'(in_height_reg);
        ow = (out_width_reg  == '0) ? DIM_W'(1) : DIM_W'(out_width_reg);
        oh = (out_height_reg == '0) ? DIM_W'(1) : DIM_W'(out_height_reg);
        rb = DIM_W'(row_begin_reg);
        re = DIM_W'(row_end_reg);
        band_end = (re < oh) ? re : oh;
        ch_raw = (channels_reg == '0) ? CH_W'(1) : channels_reg;
        nch = ({1'b0, ch_raw} > MAX_CH) ? MAX_CH[CH_W-1:0] : ch_raw;
    end

    // Shared divider and its operand selection
    always_comb
    begin
        case (cmd.div_sel)
            DIV_COL:
            begin
                div_dividend = PROD_W'(iw);
                div_divisor  = ow;
            end
            DIV_ROW:
            begin
                div_dividend = PROD_W'(ih);
                div_divisor  = oh;
            end
            DIV_MAP:
            begin
                div_dividend = prod_reg;
                div_divisor  = oh;
            end
            default:
            begin
                div_dividend = prod_reg;
                div_divisor  = oh;
            end
        endcase
    end

    nnrm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    // Remainder accumulation with carry into the mapped index
    always_comb
    begin
        col_sum   = {1'b0, col_rem_reg} + {1'b0, col_srem_reg};
        col_carry = col_sum >= {1'b0, ow};
        col_fix   = col_carry ? (col_sum - {1'b0, ow}) : col_sum;
        row_sum   = {1'b0, row_rem_reg} + {1'b0, row_srem_reg};
        row_carry = row_sum >= {1'b0, oh};
        row_fix   = row_carry ? (row_sum - {1'b0, oh}) : row_sum;
    end

    // Walk state update under controller command
    always_comb
    begin
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        map_col_next  = map_col_reg;
        map_row_next  = map_row_reg;
        col_rem_next  = col_rem_reg;
        row_rem_next  = row_rem_reg;
        col_quot_next = col_quot_reg;
        col_srem_next = col_srem_reg;
        row_quot_next = row_quot_reg;
        row_srem_next = row_srem_reg;
        started_next  = started_reg;
        if (cmd.col_reset)
        begin
            out_col_next = '0;
            map_col_next = '0;
            col_rem_next = '0;
        end
        if (cmd.col_step)
        begin
            out_col_next = out_col_reg + DIM_W'(1);
            col_rem_next = col_fix[DIM_W-1:0];
            map_col_next = map_col_reg + col_quot_reg + DIM_W'(col_carry);
        end
        if (cmd.row_step)
        begin
            out_row_next = out_row_reg + DIM_W'(1);
            row_rem_next = row_fix[DIM_W-1:0];
            map_row_next = map_row_reg + row_quot_reg + DIM_W'(row_carry);
        end
        if (cmd.load_row_map)
        begin
            out_row_next = rb;
            map_row_next = div_quot[DIM_W-1:0];
            row_rem_next = div_rem;
        end
        if (cmd.load_col_steps)
        begin
            col_quot_next = div_quot[DIM_W-1:0];
            col_srem_next = div_rem;
        end
        if (cmd.load_row_steps)
        begin
            row_quot_next = div_quot[DIM_W-1:0];
            row_srem_next = div_rem;
        end
        if (cmd.set_started)
        begin
            started_next = 1'b1;
        end
        if (cmd.clr_started)
        begin
            started_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            map_col_reg  <= '0;
            map_row_reg  <= '0;
            col_rem_reg  <= '0;
            row_rem_reg  <= '0;
            col_quot_reg <= '0;
            col_srem_reg <= '0;
            row_quot_reg <= '0;
            row_srem_reg <= '0;
            started_reg  <= 1'b0;
        end
        else
        begin
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            map_col_reg  <= map_col_next;
            map_row_reg  <= map_row_next;
            col_rem_reg  <= col_rem_next;
            row_rem_reg  <= row_rem_next;
            col_quot_reg <= col_quot_next;
            col_srem_reg <= col_srem_next;
            row_quot_reg <= row_quot_next;
            row_srem_reg <= row_srem_next;
            started_reg  <= started_next;
        end
    end

    // First band row times the source height, registered ahead of the divide
    always_ff @(posedge clk)
    begin
        if (cmd.mul_load)
        begin
            prod_reg <= PROD_W'(rb) * PROD_W'(ih);
        end
    end

    // Position tests and clamped source indices
    always_comb
    begin
        col_wrap = ({1'b0, out_col_reg} + EXT_W'(1)) >= {1'b0, ow};
        row_wrap = ({1'b0, out_row_reg} + EXT_W'(1)) >= {1'b0, band_end};
        sr = (map_row_reg > (ih - DIM_W'(1))) ? (ih - DIM_W'(1)) : map_row_reg;
        sc = (map_col_reg > (iw - DIM_W'(1))) ? (iw - DIM_W'(1)) : map_col_reg;
    end

    // Fields of the result for the channel named in the command
    always_comb
    begin
        res_new.src_row         = sr;
        res_new.src_col         = sc;
        res_new.dst_row         = out_row_reg;
        res_new.dst_col         = out_col_reg;
        res_new.channel_index   = cmd.ch;
        res_new.src_elem_offset = OFF_W'(OFF_W'(sc) * OFF_W'(nch)) + OFF_W'(cmd.ch);
        res_new.dst_elem_offset = OFF_W'(OFF_W'(out_col_reg) * OFF_W'(nch)) + OFF_W'(cmd.ch);
        res_new.last_of_pixel   = cmd.ch == (nch - CH_W'(1));
        res_new.last_of_row     = col_wrap;
        res_new.last_of_frame   = col_wrap && row_wrap;
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            result_reg <= res_new;
        end
    end

    always_comb
    begin
        status.started    = started_reg;
        status.band_empty = rb >= band_end;
        status.col_wrap   = col_wrap;
        status.row_wrap   = row_wrap;
        status.div_done   = div_done;
        status.nch        = nch;
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// ===== sv/nnrm_ctrl.sv =====
// Controller: item handshake, walk sequencing and per-channel result issue.
`default_nettype none

module nnrm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              restart,
    input  logic              m_tready,
    input  nnrm_pkg::status_t status,
    output nnrm_pkg::cmd_t    cmd,
    output logic              s_tready,
    output logic              m_tvalid
);
    import nnrm_pkg::*;

    state_t          state_reg, state_next;
    logic [CH_W-1:0] ch_reg, ch_next;

    // State and channel counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ch_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        cmd        = '0;
        cmd.div_sel = DIV_MAP;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (restart)
                    begin
                        if (status.band_empty)
                        begin
                            cmd.clr_started = 1'b1;
                        end
                        else
                        begin
                            state_next = S_COL_GO;
                        end
                    end
                    else if (status.started)
                    begin
                        if (status.band_empty)
                        begin
                            cmd.clr_started = 1'b1;
                        end
                        else
                        begin
                            state_next = S_STEP;
                        end
                    end
                end
            end
            // Move on by one pixel; the band's end reloads its first row
            S_STEP:
            begin
                if (!status.col_wrap)
                begin
                    cmd.col_step = 1'b1;
                    state_next   = S_LOAD;
                end
                else if (!status.row_wrap)
                begin
                    cmd.col_reset = 1'b1;
                    cmd.row_step  = 1'b1;
                    state_next    = S_LOAD;
                end
                else
                begin
                    cmd.col_reset = 1'b1;
                    state_next    = S_MUL;
                end
            end
            S_COL_GO:
            begin
                cmd.col_reset   = 1'b1;
                cmd.set_started = 1'b1;
                cmd.div_start   = 1'b1;
                cmd.div_sel     = DIV_COL;
                state_next      = S_COL_WAIT;
            end
            S_COL_WAIT:
            begin
                cmd.div_sel = DIV_COL;
                if (status.div_done)
                begin
                    cmd.load_col_steps = 1'b1;
                    state_next         = S_ROW_GO;
                end
            end
            S_ROW_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_ROW;
                state_next    = S_ROW_WAIT;
            end
            S_ROW_WAIT:
            begin
                cmd.div_sel = DIV_ROW;
                if (status.div_done)
                begin
                    cmd.load_row_steps = 1'b1;
                    state_next         = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_load = 1'b1;
                state_next   = S_MAP_GO;
            end
            S_MAP_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_MAP_WAIT;
            end
            S_MAP_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.load_row_map = 1'b1;
                    state_next       = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.out_load = 1'b1;
                cmd.ch       = '0;
                ch_next      = '0;
                state_next   = S_EMIT;
            end
            // One result item per channel, each held until taken
            S_EMIT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    if (ch_reg == (status.nch - CH_W'(1)))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ch_next      = ch_reg + CH_W'(1);
                        cmd.out_load = 1'b1;
                        cmd.ch       = ch_reg + CH_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/nearest_neighbor_resize_mapper_unit.sv =====
// Top level of the nearest-neighbour resize address mapper.
//
// Channel  Direction  Accepted when          Carries
// s_*      in         s_tvalid && s_tready   restart flag, one item per pixel step
// m_*      out        m_tvalid && m_tready   source/destination indices, one per channel
// cfg_*    in         cfg_we                 register write, no read-back
//
// An ordinary advance goes through the step and load states to the first result, then one
// result item per cycle for each channel while m_tready is high.
// A restart runs the shared 32-step divider three times; wrapping from the band's last
// pixel to its first runs it once.
// One item is in work at a time; results stall for as long as m_tready is low.
// Reset sets every dimension and the channel count to 1; a restart is needed first.
`default_nettype none

module nearest_neighbor_resize_mapper_unit #(
    parameter int DIM_BITS     = 16,
    parameter int MAX_CHANNELS = 3
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: [0] restart, [7:1] zero
    input  logic [nnrm_pkg::IN_DATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: src_row, src_col, dst_row, dst_col, channel_index,
    //          src_elem_offset, dst_elem_offset, two zero bits
    output logic [nnrm_pkg::OUT_DATA_W-1:0] m_tdata,
    // m_tlast: last_of_frame
    output logic                            m_tlast,
    // m_tuser: [0] last_of_pixel, [1] last_of_row
    output logic [nnrm_pkg::OUT_USER_W-1:0] m_tuser,
    input  logic                            cfg_we,
    input  logic [nnrm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nnrm_pkg::DIM_W-1:0]      cfg_data
);
    import nnrm_pkg::*;

    `include "nearest_neighbor_resize_mapper_unit_defines.svh"

    cmd_t    cmd;
    status_t status;
    result_t result;

    nnrm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .restart  (s_tdata[0]),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid)
    );

    nnrm_dp #(
        .DIM_BITS     (DIM_BITS),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

    // Pack the result item onto the stream
    assign m_tdata = {2'b00, result.dst_elem_offset, result.src_elem_offset,
                      result.channel_index, result.dst_col, result.dst_row,
                      result.src_col, result.src_row};
    assign m_tlast = result.last_of_frame;
    assign m_tuser = {result.last_of_row, result.last_of_pixel};

    // No new item is taken while a result is still on offer
    `NNRM_ASSERT_NOW(a_no_overlap, 1'b1, !(s_tready && m_tvalid), "item taken during results")
    // The end of the band is always the end of a row
    `NNRM_ASSERT_NOW(a_frame_ends_row, m_tvalid && m_tlast, m_tuser[1], "frame end off row end")
    // After the pixel's last channel is taken the block goes back to waiting
    `NNRM_ASSERT_NEXT(a_pixel_done, m_tvalid && m_tready && m_tuser[0], !m_tvalid, "extra result")
    // Channels of one pixel follow one another
    `NNRM_ASSERT_NEXT(a_next_channel, m_tvalid && m_tready && !m_tuser[0], m_tvalid && (m_tdata[65:64] == ($past(m_tdata[65:64]) + 2'd1)), "channel skipped")

endmodule

`default_nettype wire

// ===== dv/nearest_neighbor_resize_mapper_unit_test.sv =====
// Self-checking testbench for the nearest-neighbour resize address mapper.
`timescale 1ns / 1ps

module nearest_neighbor_resize_mapper_unit_test;

    import nnrm_pkg::*;

    localparam int SETTLE_CYCLES = 250;
    localparam int HOLD_AT       = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int ITEM_TARGET   = 380;

    // Clock, reset and the ports of the block.
    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // s_tdata: [0] restart, [7:1] zero
    logic [IN_DATA_W-1:0]   s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // m_tdata: src_row, src_col, dst_row, dst_col, channel_index,
    //          src_elem_offset, dst_elem_offset, two zero bits
    logic [OUT_DATA_W-1:0]  m_tdata;
    // m_tlast: last_of_frame
    logic                   m_tlast;
    // m_tuser: [0] last_of_pixel, [1] last_of_row
    logic [OUT_USER_W-1:0]  m_tuser;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [DIM_W-1:0]       cfg_data = '0;

    // Handshake flags seen at the last rising edge.
    bit in_fire  = 1'b0;
    bit out_fire = 1'b0;

    // Stimulus and scoreboard storage.
    bit          restart_flags[$];
    result_t     predicted_maps[$];
    int unsigned fault_count    = 0;
    int unsigned items_taken    = 0;
    int unsigned maps_taken     = 0;
    int unsigned send_gap       = 0;
    int unsigned take_gap       = 0;
    int unsigned hold_left      = 0;
    bit          no_idle        = 1'b0;

    // Shadow copy of the registers.
    bit [15:0] cfg_in_w      = 16'd1;
    bit [15:0] cfg_in_h      = 16'd1;
    bit [15:0] cfg_out_w     = 16'd1;
    bit [15:0] cfg_out_h     = 16'd1;
    bit [1:0]  cfg_channels  = 2'd1;
    bit [15:0] cfg_row_begin = 16'd0;
    bit [15:0] cfg_row_end   = 16'd1;

    // Walk state of the predictor.
    bit [15:0] pix_col  = '0;
    bit [15:0] pix_row  = '0;
    bit [15:0] near_col = '0;
    bit [15:0] near_row = '0;
    bit [15:0] col_frac = '0;
    bit [15:0] row_frac = '0;
    bit [15:0] col_q    = '0;
    bit [15:0] col_r    = '0;
    bit [15:0] row_q    = '0;
    bit [15:0] row_r    = '0;
    bit        walking  = 1'b0;

    nearest_neighbor_resize_mapper_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Free-running clock with a 20 ns period.
    initial
    begin
        forever #10 clk = ~clk;
    end

    // A zero dimension behaves as one.
    function automatic int unsigned at_least_one(input int unsigned v);
        return (v == 0) ? 1 : v;
    endfunction

    // Row that closes the band, never beyond the destination height.
    function automatic int unsigned band_stop();
        int unsigned oh;
        oh = at_least_one(cfg_out_h);
        return (cfg_row_end < oh) ? cfg_row_end : oh;
    endfunction

    // Exact source row and remainder for destination row y.
    task automatic seed_row(input int unsigned y);
        longint unsigned prod;
        int unsigned     oh;
        oh   = at_least_one(cfg_out_h);
        prod = y;
        prod = prod * at_least_one(cfg_in_h);
        pix_row  = y[15:0];
        near_row = 16'(prod / oh);
        row_frac = 16'(prod % oh);
    endtask

    // Move one destination pixel on in raster order, wrapping at the band end.
    task automatic step_walk();
        int unsigned ow;
        int unsigned oh;
        int unsigned frac;
        int unsigned near;
        ow = at_least_one(cfg_out_w);
        oh = at_least_one(cfg_out_h);
        if (int'(pix_col) + 1 < ow)
        begin
            frac = col_frac + col_r;
            near = near_col + col_q;
            if (frac >= ow)
            begin
                frac = frac - ow;
                near = near + 1;
            end
            pix_col  = pix_col + 16'd1;
            col_frac = frac[15:0];
            near_col = near[15:0];
            return;
        end
        pix_col  = '0;
        near_col = '0;
        col_frac = '0;
        if (int'(pix_row) + 1 < band_stop())
        begin
            frac = row_frac + row_r;
            near = near_row + row_q;
            if (frac >= oh)
            begin
                frac = frac - oh;
                near = near + 1;
            end
            pix_row  = pix_row + 16'd1;
            row_frac = frac[15:0];
            near_row = near[15:0];
        end
        else
        begin
            seed_row(cfg_row_begin);
        end
    endtask

    // Work out the channel results caused by one accepted item.
    task automatic predict_pixel_maps(input bit restart);
        int unsigned iw;
        int unsigned ih;
        int unsigned ow;
        int unsigned nch;
        int unsigned sr;
        int unsigned sc;
        bit          lrow;
        bit          lframe;
        result_t     map;
        iw = at_least_one(cfg_in_w);
        ih = at_least_one(cfg_in_h);
        ow = at_least_one(cfg_out_w);
        if (restart)
        begin
            // An empty band stops the walk and gives nothing.
            if (cfg_row_begin >= band_stop())
            begin
                walking = 1'b0;
                return;
            end
            col_q    = 16'(iw / ow);
            col_r    = 16'(iw % ow);
            row_q    = 16'(ih / at_least_one(cfg_out_h));
            row_r    = 16'(ih % at_least_one(cfg_out_h));
            pix_col  = '0;
            near_col = '0;
            col_frac = '0;
            seed_row(cfg_row_begin);
            walking  = 1'b1;
        end
        else
        begin
            // Advancing before any restart is ignored.
            if (!walking)
                return;
            if (cfg_row_begin >= band_stop())
            begin
                walking = 1'b0;
                return;
            end
            step_walk();
        end
        nch    = (cfg_channels == 0) ? 1 : cfg_channels;
        sr     = (near_row > ih - 1) ? ih - 1 : near_row;
        sc     = (near_col > iw - 1) ? iw - 1 : near_col;
        lrow   = (int'(pix_col) + 1 >= ow);
        lframe = lrow && (int'(pix_row) + 1 >= band_stop());
        for (int unsigned c = 0; c < nch; c++)
        begin
            map.src_row         = sr[15:0];
            map.src_col         = sc[15:0];
            map.dst_row         = pix_row;
            map.dst_col         = pix_col;
            map.channel_index   = c[1:0];
            map.src_elem_offset = 18'(sc * nch + c);
            map.dst_elem_offset = 18'(pix_col * nch + c);
            map.last_of_pixel   = (c + 1 == nch);
            map.last_of_row     = lrow;
            map.last_of_frame   = lframe;
            predicted_maps.push_back(map);
        end
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            fault_count++;
        end
    endtask

    // Compare one accepted result with the oldest prediction.
    task automatic check_map();
        result_t want;
        result_t got;
        got.src_row         = m_tdata[15:0];
        got.src_col         = m_tdata[31:16];
        got.dst_row         = m_tdata[47:32];
        got.dst_col         = m_tdata[63:48];
        got.channel_index   = m_tdata[65:64];
        got.src_elem_offset = m_tdata[83:66];
        got.dst_elem_offset = m_tdata[101:84];
        got.last_of_pixel   = m_tuser[0];
        got.last_of_row     = m_tuser[1];
        got.last_of_frame   = m_tlast;
        if (predicted_maps.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
            fault_count++;
            return;
        end
        want = predicted_maps.pop_front();
        compare_field("src_row", want.src_row, got.src_row);
        compare_field("src_col", want.src_col, got.src_col);
        compare_field("dst_row", want.dst_row, got.dst_row);
        compare_field("dst_col", want.dst_col, got.dst_col);
        compare_field("channel_index", want.channel_index, got.channel_index);
        compare_field("src_elem_offset", want.src_elem_offset, got.src_elem_offset);
        compare_field("dst_elem_offset", want.dst_elem_offset, got.dst_elem_offset);
        compare_field("last_of_pixel", want.last_of_pixel, got.last_of_pixel);
        compare_field("last_of_row", want.last_of_row, got.last_of_row);
        compare_field("last_of_frame", want.last_of_frame, got.last_of_frame);
    endtask

    // Monitor: sample both handshakes at the rising edge.
    always @(posedge clk)
    begin
        in_fire  = rst_n && s_tvalid && s_tready;
        out_fire = rst_n && m_tvalid && m_tready;
        if (in_fire)
        begin
            items_taken++;
            predict_pixel_maps(s_tdata[0]);
        end
        if (out_fire)
            check_map();
    end

    // Driver: offer pending items with a random gap after each acceptance.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else if (!s_tvalid || in_fire)
        begin
            if (send_gap > 0)
            begin
                send_gap = send_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (restart_flags.size() > 0)
            begin
                s_tdata  <= {7'd0, restart_flags.pop_front()};
                s_tvalid <= 1'b1;
                send_gap = no_idle ? 0 : $urandom_range(0, 3);
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls per result, and one long hold-off to back up the input.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (out_fire)
            begin
                maps_taken++;
                take_gap = no_idle ? 0 : $urandom_range(0, 3);
                if (maps_taken == HOLD_AT)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end
            else if (take_gap > 0)
            begin
                take_gap = take_gap - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Register write while the block is idle; the shadow copy follows.
    task automatic write_reg(input cfg_reg_t idx, input bit [15:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        case (idx)
            REG_IN_WIDTH:   cfg_in_w      = value;
            REG_IN_HEIGHT:  cfg_in_h      = value;
            REG_OUT_WIDTH:  cfg_out_w     = value;
            REG_OUT_HEIGHT: cfg_out_h     = value;
            REG_CHANNELS:   cfg_channels  = value[1:0];
            REG_ROW_BEGIN:  cfg_row_begin = value;
            REG_ROW_END:    cfg_row_end   = value;
            default:        ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_geometry(input bit [15:0] iw, input bit [15:0] ih,
                                input bit [15:0] ow, input bit [15:0] oh,
                                input bit [15:0] ch, input bit [15:0] rb,
                                input bit [15:0] re);
        write_reg(REG_IN_WIDTH, iw);
        write_reg(REG_IN_HEIGHT, ih);
        write_reg(REG_OUT_WIDTH, ow);
        write_reg(REG_OUT_HEIGHT, oh);
        write_reg(REG_CHANNELS, ch);
        write_reg(REG_ROW_BEGIN, rb);
        write_reg(REG_ROW_END, re);
    endtask

    // Queue one restart item followed by a number of advances.
    task automatic queue_walk(input int unsigned advances);
        restart_flags.push_back(1'b1);
        repeat (advances)
            restart_flags.push_back(1'b0);
    endtask

    // Wait until every item is taken and every result has arrived, then let
    // any result-less item finish inside the block.
    task automatic settle_pipeline();
        @(posedge clk);
        while (restart_flags.size() != 0 || s_tvalid)
            @(posedge clk);
        while (predicted_maps.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Random dimension: mostly small, sometimes zero, all ones or any value.
    function automatic bit [15:0] pick_dim();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 6)
            return 16'd0;
        if (roll < 12)
            return 16'hFFFF;
        if (roll < 18)
            return 16'($urandom);
        return 16'($urandom_range(1, 12));
    endfunction

    // Main sequence: directed phases, then random phases.
    initial
    begin
        int unsigned n_items;
        int unsigned roll;
        int unsigned restart_pct;
        bit [15:0]   rb;
        bit [15:0]   re;
        bit [15:0]   ch;

        no_idle = 1'b1;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Reset values: an advance before any restart, then a one-pixel band.
        restart_flags.push_back(1'b0);
        restart_flags.push_back(1'b1);
        restart_flags.push_back(1'b0);
        settle_pipeline();

        // Small band with three channels, walked to its last pixel.
        no_idle = 1'b0;
        set_geometry(16'd5, 16'd7, 16'd3, 16'd4, 16'd3, 16'd1, 16'd3);
        queue_walk(5);
        settle_pipeline();

        // Registers changed mid-walk: narrower output and fewer channels.
        write_reg(REG_CHANNELS, 16'd2);
        write_reg(REG_OUT_WIDTH, 16'd2);
        restart_flags.push_back(1'b0);
        restart_flags.push_back(1'b0);
        restart_flags.push_back(1'b0);
        settle_pipeline();

        // Empty band: advance clears the walk, restart and advance give nothing.
        write_reg(REG_ROW_BEGIN, 16'd3);
        write_reg(REG_ROW_END, 16'd3);
        restart_flags.push_back(1'b0);
        restart_flags.push_back(1'b1);
        restart_flags.push_back(1'b0);
        settle_pipeline();

        // Zero dimensions and zero channels, band end beyond the image.
        set_geometry(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd5);
        queue_walk(2);
        settle_pipeline();

        // Largest dimensions with the last possible band row.
        set_geometry(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd3, 16'hFFFE, 16'hFFFF);
        queue_walk(2);
        settle_pipeline();

        // Strong downscale to one column and two rows.
        set_geometry(16'hFFFF, 16'hFFFF, 16'd1, 16'd2, 16'd1, 16'd0, 16'hFFFF);
        queue_walk(3);
        settle_pipeline();

        // Random phases until enough items have been sent.
        while (items_taken < ITEM_TARGET)
        begin
            no_idle = ($urandom_range(0, 99) < 20);
            roll = $urandom_range(0, 99);
            if (roll < 10)
            begin
                rb = 16'($urandom_range(0, 8));
                re = 16'($urandom_range(0, rb));
            end
            else if (roll < 18)
            begin
                rb = 16'($urandom);
                re = 16'($urandom);
            end
            else if (roll < 26)
            begin
                rb = 16'($urandom_range(0, 4));
                re = 16'hFFFF;
            end
            else
            begin
                rb = 16'($urandom_range(0, 6));
                re = rb + 16'($urandom_range(1, 4));
            end
            ch = 16'($urandom_range(0, 3));
            if ($urandom_range(0, 99) < 10)
                ch[15:2] = 14'($urandom);
            set_geometry(pick_dim(), pick_dim(), pick_dim(), pick_dim(), ch, rb, re);

            // Mostly a restart followed by advances; some phases are noise.
            restart_pct = ($urandom_range(0, 99) < 10) ? 50 : 4;
            n_items = $urandom_range(12, 36);
            if ($urandom_range(0, 99) < 85)
                restart_flags.push_back(1'b1);
            repeat (n_items)
                restart_flags.push_back($urandom_range(0, 99) < restart_pct);
            settle_pipeline();
        end

        if (predicted_maps.size() != 0)
        begin
            $display("%0t: %0d results expected, got none", $time, predicted_maps.size());
            fault_count++;
        end
        if (fault_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #10ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/nnrm_pkg.sv
sv/nnrm_div.sv
sv/nnrm_dp.sv
sv/nnrm_ctrl.sv
sv/nearest_neighbor_resize_mapper_unit.sv
dv/nearest_neighbor_resize_mapper_unit_test.sv
